/* src/hfua_pkg.sv */
// types and constants shared by the fu-a packetizer modules
package hfua_pkg;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1400;
    localparam logic [15:0] MIN_LIMIT         = 16'd2;
    localparam logic [7:0]  FU_NRI_MASK       = 8'h60;
    localparam logic [7:0]  FU_A_TYPE         = 8'd28;
    localparam logic [7:0]  NAL_TYPE_MASK     = 8'h1F;
    localparam logic [7:0]  FU_START_BIT      = 8'h80;
    localparam logic [7:0]  FU_END_BIT        = 8'h40;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        nal_start;
        logic [15:0] nal_length;
    } t_nal_beat;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        packet_first;
        logic        packet_last;
        logic [15:0] sequence_number;
        logic        fragmented;
        logic        last_of_item;
    } t_result;

    // up to three results from one input beat, res[0] goes out first
    typedef struct packed {
        logic [1:0]      count;
        t_result [2:0]   res;
    } t_burst;

endpackage

/* src/hfua_if.sv */
// valid/ready channel interfaces for nal input beats and payload output beats
interface hfua_nal_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        nal_start;
    logic [15:0] nal_length;

    modport source (output valid, output data_byte, output nal_start, output nal_length,
                    input ready);
    modport sink   (input valid, input data_byte, input nal_start, input nal_length,
                    output ready);
endinterface

interface hfua_pay_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        packet_first;
    logic        packet_last;
    logic [15:0] sequence_number;
    logic        fragmented;
    logic        last_of_item;

    modport source (output valid, output out_byte, output packet_first, output packet_last,
                    output sequence_number, output fragmented, output last_of_item,
                    input ready);
    modport sink   (input valid, input out_byte, input packet_first, input packet_last,
                    input sequence_number, input fragmented, input last_of_item,
                    output ready);
endinterface

/* src/h264_rtp_fua_packetizer_unit.sv */
// top level of the h.264 rtp single-nal / fu-a packetizer
//
//  channel   dir  handshake            beat contents
//  i_nal     in   valid/ready          data_byte, nal_start, nal_length
//  o_pay     out  valid/ready          out_byte, packet_first, packet_last,
//                                      sequence_number, fragmented, last_of_item
//  cfg       in   i_cfg_we (no ready)  i_cfg_wdata = max_payload
//
// one input beat per cycle while o_pay is ready; a byte that opens an fu-a
// fragment gives three output beats and holds the input while the three-entry
// result register drains. synchronous reset clears the valid flags and the
// packetizer state, the sequence number to zero and max_payload to 1400. a stall
// on o_pay backs up through the result register to i_nal.ready.
module h264_rtp_fua_packetizer_unit import hfua_pkg::*; #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    hfua_nal_if.sink    i_nal,
    hfua_pay_if.source  o_pay
);

    t_burst burst;
    logic   push;
    logic   take;

    hfua_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_nal       (i_nal),
        .i_take      (take),
        .o_burst     (burst),
        .o_push      (push)
    );

    hfua_burst u_burst (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_burst (burst),
        .o_take  (take),
        .o_pay   (o_pay)
    );

endmodule

/* src/hfua_step.sv */
// input register, packetizer state and the per-beat result logic
module hfua_step import hfua_pkg::*; #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    hfua_nal_if.sink    i_nal,
    input  logic        i_take,
    output t_burst      o_burst,
    output logic        o_push
);

    localparam int LB = LENGTH_BITS;
    localparam int CW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

    logic            r_in_valid;
    t_nal_beat       r_in;
    logic [15:0]     r_max_payload;
    logic [15:0]     r_counter, n_counter;
    logic [7:0]      r_hdr, n_hdr;
    logic [LB-1:0]   r_left_nal, n_left_nal;
    logic [LB-1:0]   r_left_frag, n_left_frag;
    logic            r_split, n_split;
    logic            r_ffp, n_ffp;

    logic            adv;
    logic [CW-1:0]   lim_w, len_w, len1_w, left_nal_w, n_w;
    logic [31:0]     len_pad;
    logic            open_pkt;
    logic [LB-1:0]   frag_cnt, frag_dec, nal_dec;
    logic [7:0]      fu_hdr;
    t_burst          burst;

    function automatic t_result mk_result(input logic [7:0] b, input logic first,
                                          input logic last, input logic frag,
                                          input logic [15:0] seq, input logic eoi);
        t_result r;
        r.out_byte        = b;
        r.packet_first    = first;
        r.packet_last     = last;
        r.sequence_number = seq;
        r.fragmented      = frag;
        r.last_of_item    = eoi;
        return r;
    endfunction

    assign adv         = r_in_valid && i_take;
    assign i_nal.ready = !r_in_valid || i_take;
    assign o_push      = adv;
    assign o_burst     = burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_nal.ready) begin
            r_in_valid <= i_nal.valid;
        end
        if (i_nal.valid && i_nal.ready) begin
            r_in.data_byte  <= i_nal.data_byte;
            r_in.nal_start  <= i_nal.nal_start;
            r_in.nal_length <= i_nal.nal_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (i_cfg_we) begin
            r_max_payload <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter   <= '0;
            r_hdr       <= '0;
            r_left_nal  <= '0;
            r_left_frag <= '0;
            r_split     <= 1'b0;
            r_ffp       <= 1'b0;
        end else if (adv) begin
            r_counter   <= n_counter;
            r_hdr       <= n_hdr;
            r_left_nal  <= n_left_nal;
            r_left_frag <= n_left_frag;
            r_split     <= n_split;
            r_ffp       <= n_ffp;
        end
    end

    // length masked to LENGTH_BITS, compared at the wider of the two widths
    always_comb begin
        lim_w      = CW'((r_max_payload < MIN_LIMIT) ? MIN_LIMIT : r_max_payload);
        len_pad    = 32'(r_in.nal_length);
        for (int i = 0; i < CW; i++) begin
            len_w[i] = (i < LB) ? len_pad[i] : 1'b0;
        end
        len1_w     = (len_w == '0) ? CW'(1) : len_w;
        left_nal_w = CW'(r_left_nal);
        open_pkt   = (!r_split && r_left_nal != '0) || (r_split && r_left_frag != '0);

        // size of a fragment that starts now; never start and end together
        n_w = (left_nal_w < lim_w) ? left_nal_w : lim_w;
        if (r_ffp && n_w == left_nal_w && n_w > CW'(1)) begin
            n_w = n_w - CW'(1);
        end
        fu_hdr = r_hdr & NAL_TYPE_MASK;
        if (r_ffp) begin
            fu_hdr = fu_hdr | FU_START_BIT;
        end else if (n_w == left_nal_w) begin
            fu_hdr = fu_hdr | FU_END_BIT;
        end
        frag_cnt = (r_left_frag == '0) ? LB'(n_w) : r_left_frag;
        frag_dec = frag_cnt - LB'(1);
        nal_dec  = r_left_nal - LB'(1);
    end

    always_comb begin
        n_counter   = r_counter;
        n_hdr       = r_hdr;
        n_left_nal  = r_left_nal;
        n_left_frag = r_left_frag;
        n_split     = r_split;
        n_ffp       = r_ffp;
        burst       = '0;

        if (r_in.nal_start) begin
            n_left_frag = '0;
            n_ffp       = 1'b0;
            n_left_nal  = LB'(len1_w - CW'(1));
            if (len1_w <= lim_w) begin
                n_split      = 1'b0;
                burst.count  = 2'd1;
                burst.res[0] = mk_result(r_in.data_byte, 1'b1, len1_w == CW'(1), 1'b0,
                                         r_counter + 16'(open_pkt), 1'b1);
                n_counter    = r_counter + 16'(open_pkt) + 16'(len1_w == CW'(1));
            end else begin
                n_split   = 1'b1;
                n_hdr     = r_in.data_byte;
                n_ffp     = 1'b1;
                n_counter = r_counter + 16'(open_pkt);
            end
        end else if (r_left_nal == '0) begin
            // stray byte outside a unit
            burst.count = 2'd0;
        end else if (!r_split) begin
            n_left_nal   = nal_dec;
            burst.count  = 2'd1;
            burst.res[0] = mk_result(r_in.data_byte, 1'b0, nal_dec == '0, 1'b0,
                                     r_counter, 1'b1);
            n_counter    = r_counter + 16'(nal_dec == '0);
        end else begin
            if (r_left_frag == '0) begin
                burst.count  = 2'd3;
                burst.res[0] = mk_result((r_hdr & FU_NRI_MASK) | FU_A_TYPE, 1'b1, 1'b0,
                                         1'b1, r_counter, 1'b0);
                burst.res[1] = mk_result(fu_hdr, 1'b0, 1'b0, 1'b1, r_counter, 1'b0);
                burst.res[2] = mk_result(r_in.data_byte, 1'b0, frag_dec == '0, 1'b1,
                                         r_counter, 1'b1);
                n_ffp        = 1'b0;
            end else begin
                burst.count  = 2'd1;
                burst.res[0] = mk_result(r_in.data_byte, 1'b0, frag_dec == '0, 1'b1,
                                         r_counter, 1'b1);
            end
            n_left_frag = frag_dec;
            n_left_nal  = nal_dec;
            n_counter   = r_counter + 16'(frag_dec == '0);
            if (nal_dec == '0) begin
                n_split     = 1'b0;
                n_left_frag = '0;
            end
        end
    end

    a_split_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_split |-> (r_left_nal != '0))
        else $error("split mode with no bytes left in the unit");

    a_frag_within_nal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left_frag <= r_left_nal)
        else $error("fragment runs past the end of the unit");

    a_first_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ffp |-> (r_split && r_left_frag == '0))
        else $error("first fragment pending outside a split unit");

endmodule

/* src/hfua_burst.sv */
// result register for one beat's results, one out per cycle while o_pay is ready
module hfua_burst import hfua_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_burst      i_burst,
    output logic        o_take,
    hfua_pay_if.source  o_pay
);

    t_result [2:0] r_slot;
    logic [1:0]    r_n;
    logic          pop;

    assign pop    = o_pay.valid && o_pay.ready;
    // room for a new burst once the last held result leaves
    assign o_take = (r_n == 2'd0) || (r_n == 2'd1 && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= 2'd0;
        end else if (i_push) begin
            r_n <= i_burst.count;
        end else if (pop) begin
            r_n <= r_n - 2'd1;
        end
        if (i_push) begin
            r_slot <= i_burst.res;
        end else if (pop) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

    assign o_pay.valid           = (r_n != 2'd0);
    assign o_pay.out_byte        = r_slot[0].out_byte;
    assign o_pay.packet_first    = r_slot[0].packet_first;
    assign o_pay.packet_last     = r_slot[0].packet_last;
    assign o_pay.sequence_number = r_slot[0].sequence_number;
    assign o_pay.fragmented      = r_slot[0].fragmented;
    assign o_pay.last_of_item    = r_slot[0].last_of_item;

    a_last_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pay.valid |-> (r_slot[0].last_of_item == (r_n == 2'd1)))
        else $error("last_of_item out of step with held result count");

endmodule
